// ===== hw/rtl/ifmt_pkg.sv =====
// Shared types, constants and a helper function for the integer field formatter.
`timescale 1ns / 1ps
package ifmt_pkg;

  localparam int OUT_LIMIT = 63;
  localparam int CHAR_BITS = 8;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 8'h41;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;

  typedef enum logic [1:0] {
    ALIGN_LEFT,
    ALIGN_ZERO,
    ALIGN_RIGHT
  } align_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] sign_code;
    logic                 has_sign;
    logic [5:0]           radix;
    logic                 upper;
    logic [5:0]           width;
    align_t               align;
  } desc_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [5:0] d,
                                                     input logic upper);
    logic [CHAR_BITS-1:0] base;
    base = upper ? CHAR_UP_A : CHAR_LOW_A;
    if (d < 6'd10) begin
      digit_char = CHAR_ZERO + {2'b00, d};
    end else begin
      digit_char = base + {2'b00, d} - 8'd10;
    end
  endfunction

endpackage

// ===== hw/rtl/integer_field_formatter.sv =====
// Top level of the integer field formatter.
`timescale 1ns / 1ps
// Formats one integer request into a padded text field in radix 2 to 36 and
// delivers it one ASCII character per result, with last set on the final one.
// A request waits in a two-entry queue after classification; the back end
// converts its magnitude digit by digit with a bit-serial restoring divider,
// passes a setup state, and then emits one character per cycle while the
// output queue has room.
module integer_field_formatter #(
  parameter int VALUE_BITS      = 32,
  parameter int MAX_FIELD_WIDTH = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  is_signed,
  input  logic [5:0]            radix,
  input  logic                  upper_case,
  input  logic [5:0]            field_width,
  input  logic                  pad_after,
  input  logic                  plus_sign,
  input  logic                  blank_sign,
  input  logic                  zero_pad,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_char,
  output logic                  last
);

  import ifmt_pkg::*;

  localparam int DESC_DEPTH = 2;
  localparam int OUT_DEPTH  = 4;
  localparam int QW         = VALUE_BITS + $bits(desc_t);

  desc_t                       f_desc;
  logic [VALUE_BITS-1:0]       f_mag;
  logic [QW-1:0]               q_out;
  logic                        q_empty;
  logic                        q_pop;
  logic [$clog2(DESC_DEPTH):0] q_level;
  desc_t                       b_desc;
  logic [VALUE_BITS-1:0]       b_mag;
  logic [$clog2(OUT_DEPTH):0]  o_level;
  logic                        o_push;
  logic [7:0]                  o_char;
  logic                        o_last;
  logic                        o_full;

  ifmt_front #(
    .VALUE_BITS      (VALUE_BITS),
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_front (
    .value       (value),
    .is_signed   (is_signed),
    .radix       (radix),
    .upper_case  (upper_case),
    .field_width (field_width),
    .pad_after   (pad_after),
    .plus_sign   (plus_sign),
    .blank_sign  (blank_sign),
    .zero_pad    (zero_pad),
    .desc        (f_desc),
    .mag         (f_mag)
  );

  ifmt_fifo #(
    .WIDTH (QW),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .din   ({f_desc, f_mag}),
    .full  (full),
    .rd    (q_pop),
    .dout  (q_out),
    .empty (q_empty),
    .level (q_level)
  );

  assign b_desc = q_out[QW-1:VALUE_BITS];
  assign b_mag  = q_out[VALUE_BITS-1:0];

  ifmt_back #(
    .VALUE_BITS (VALUE_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_empty (q_empty || (q_level == '0)),
    .desc_in    (b_desc),
    .mag_in     (b_mag),
    .desc_pop   (q_pop),
    .out_level  (o_level),
    .out_push   (o_push),
    .out_char   (o_char),
    .out_last   (o_last)
  );

  ifmt_fifo #(
    .WIDTH (9),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (o_push && !o_full),
    .din   ({o_char, o_last}),
    .full  (o_full),
    .rd    (pop),
    .dout  ({out_char, last}),
    .empty (empty),
    .level (o_level)
  );

endmodule

// ===== hw/rtl/ifmt_fifo.sv =====
// Small show-ahead queue used between the front, the back and the result port.
`timescale 1ns / 1ps
module ifmt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr,
  input  logic [WIDTH-1:0]         din,
  output logic                     full,
  input  logic                     rd,
  output logic [WIDTH-1:0]         dout,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   level
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign level = count;
  assign dout  = store[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= din;
    end
  end

endmodule

// ===== hw/rtl/ifmt_front.sv =====
// Front end: classifies a request into sign, magnitude, radix, letter case, width and alignment.
`timescale 1ns / 1ps
module ifmt_front #(
  parameter int VALUE_BITS      = 32,
  parameter int MAX_FIELD_WIDTH = 63
) (
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  is_signed,
  input  logic [5:0]            radix,
  input  logic                  upper_case,
  input  logic [5:0]            field_width,
  input  logic                  pad_after,
  input  logic                  plus_sign,
  input  logic                  blank_sign,
  input  logic                  zero_pad,
  output ifmt_pkg::desc_t       desc,
  output logic [VALUE_BITS-1:0] mag
);

  import ifmt_pkg::*;

  localparam logic [5:0] WIDTH_MAX = 6'(MAX_FIELD_WIDTH);

  logic neg;

  assign neg = is_signed && value[VALUE_BITS-1];
  assign mag = neg ? (~value + 1'b1) : value;

  always_comb begin
    desc = '0;
    if (neg) begin
      desc.sign_code = CHAR_MINUS;
      desc.has_sign  = 1'b1;
    end else if (is_signed && plus_sign) begin
      desc.sign_code = CHAR_PLUS;
      desc.has_sign  = 1'b1;
    end else if (is_signed && blank_sign) begin
      desc.sign_code = CHAR_SPACE;
      desc.has_sign  = 1'b1;
    end
    if (radix < RADIX_MIN) begin
      desc.radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      desc.radix = RADIX_MAX;
    end else begin
      desc.radix = radix;
    end
    desc.upper = upper_case;
    desc.width = (field_width > WIDTH_MAX) ? WIDTH_MAX : field_width;
    if (pad_after) begin
      desc.align = ALIGN_LEFT;
    end else if (zero_pad) begin
      desc.align = ALIGN_ZERO;
    end else begin
      desc.align = ALIGN_RIGHT;
    end
  end

endmodule

// ===== hw/rtl/ifmt_back.sv =====
// Back end: bit-serial digit conversion, then emission of the padded field.
`timescale 1ns / 1ps
module ifmt_back #(
  parameter int VALUE_BITS = 32,
  parameter int OUT_DEPTH  = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         desc_empty,
  input  ifmt_pkg::desc_t              desc_in,
  input  logic [VALUE_BITS-1:0]        mag_in,
  output logic                         desc_pop,
  input  logic [$clog2(OUT_DEPTH):0]   out_level,
  output logic                         out_push,
  output logic [7:0]                   out_char,
  output logic                         out_last
);

  import ifmt_pkg::*;

  localparam int AW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DCW = $clog2(VALUE_BITS + 1);
  localparam int LW  = ($clog2(VALUE_BITS + 2) > 6) ? $clog2(VALUE_BITS + 2) : 6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SETUP,
    S_EMIT
  } state_t;

  state_t                state;
  desc_t                 d;
  logic [VALUE_BITS-1:0] work;
  logic [5:0]            rem;
  logic [AW-1:0]         bit_cnt;
  logic [DCW-1:0]        ndig;
  logic [LW-1:0]         pad;
  logic [5:0]            count;
  logic [5:0]            pos;
  logic [7:0]            digits [VALUE_BITS];
  logic [7:0]            rd_data;
  logic                  b_valid;
  logic                  b_digit;
  logic [7:0]            b_fixed;
  logic                  b_last;

  logic [6:0]            rem_sh;
  logic                  ge;
  logic [6:0]            rem_new;
  logic [VALUE_BITS-1:0] work_new;
  logic [LW-1:0]         body;
  logic [LW-1:0]         len;
  logic [LW-1:0]         p;
  logic [LW-1:0]         s;
  logic [LW-1:0]         k;
  logic [LW-1:0]         addr_full;
  logic                  sel_digit;
  logic [7:0]            sel_fixed;
  logic                  issue;
  logic                  is_last;

  assign rem_sh   = {rem, work[VALUE_BITS-1]};
  assign ge       = rem_sh >= {1'b0, d.radix};
  assign rem_new  = ge ? (rem_sh - {1'b0, d.radix}) : rem_sh;
  assign work_new = {work[VALUE_BITS-2:0], ge};

  assign body = LW'(ndig) + LW'(d.has_sign);
  assign len  = (LW'(d.width) > body) ? LW'(d.width) : body;

  assign s       = LW'(d.has_sign);
  assign p       = LW'(pos);
  assign issue   = (state == S_EMIT) &&
                   ((LW'(out_level) + LW'(b_valid)) < LW'(OUT_DEPTH));
  assign is_last = (pos == count - 6'd1);

  always_comb begin
    sel_digit = 1'b0;
    sel_fixed = CHAR_SPACE;
    k         = '0;
    case (d.align)
      ALIGN_LEFT: begin
        if ((s != '0) && (p == '0)) begin
          sel_fixed = d.sign_code;
        end else if ((p - s) < LW'(ndig)) begin
          sel_digit = 1'b1;
          k         = p - s;
        end
      end
      ALIGN_ZERO: begin
        if (p < s) begin
          sel_fixed = d.sign_code;
        end else if (p < s + pad) begin
          sel_fixed = CHAR_ZERO;
        end else begin
          sel_digit = 1'b1;
          k         = p - s - pad;
        end
      end
      ALIGN_RIGHT: begin
        if (p < pad) begin
          sel_fixed = CHAR_SPACE;
        end else if (p < pad + s) begin
          sel_fixed = d.sign_code;
        end else begin
          sel_digit = 1'b1;
          k         = p - pad - s;
        end
      end
      default: begin
        sel_fixed = CHAR_SPACE;
      end
    endcase
  end

  assign addr_full = LW'(ndig) - LW'(1) - k;
  assign desc_pop  = (state == S_IDLE) && !desc_empty;
  assign out_push  = b_valid;
  assign out_char  = b_digit ? rd_data : b_fixed;
  assign out_last  = b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      b_valid <= 1'b0;
    end else begin
      b_valid <= issue;
      case (state)
        S_IDLE: begin
          if (!desc_empty) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if ((bit_cnt == AW'(VALUE_BITS - 1)) && (work_new == '0)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (issue && is_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        d       <= desc_in;
        work    <= mag_in;
        rem     <= '0;
        bit_cnt <= '0;
        ndig    <= '0;
      end
      S_CONV: begin
        if (bit_cnt == AW'(VALUE_BITS - 1)) begin
          digits[ndig[AW-1:0]] <= digit_char(rem_new[5:0], d.upper);
          ndig    <= ndig + 1'b1;
          work    <= work_new;
          rem     <= '0;
          bit_cnt <= '0;
        end else begin
          work    <= work_new;
          rem     <= rem_new[5:0];
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
      S_SETUP: begin
        pad   <= len - body;
        count <= (len > LW'(OUT_LIMIT)) ? 6'(OUT_LIMIT) : len[5:0];
        pos   <= '0;
      end
      S_EMIT: begin
        if (issue) begin
          rd_data <= digits[addr_full[AW-1:0]];
          b_digit <= sel_digit;
          b_fixed <= sel_fixed;
          b_last  <= is_last;
          pos     <= pos + 6'd1;
        end
      end
      default: begin
        pos <= '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ifmt_checker.sv =====
// Port-level checks for the integer field formatter and their bind.
`timescale 1ns / 1ps
module ifmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       last
);

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // Every waiting character lies between a space and a lowercase z, which covers spaces, signs, digits and letters.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_char >= 8'h20) && (out_char <= 8'h7a))
    else $error("character out of range");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_char) && $stable(last))
    else $error("waiting result changed");

  // The final character of a field is never a minus or plus sign.
  a_last_not_sign: assert property (@(posedge clk) disable iff (rst)
    !empty && last |-> (out_char != 8'h2d) && (out_char != 8'h2b))
    else $error("field ends in a sign");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_char (out_char),
  .last     (last)
);

// ===== bench/integer_field_formatter_tb.sv =====
// Self-checking testbench for the integer field formatter with random idling.
`timescale 1ns / 1ps
module integer_field_formatter_tb;
  import ifmt_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [31:0] value = '0;
  logic is_signed = 1'b0;
  logic [5:0] radix = 6'd10;
  logic upper_case = 1'b0;
  logic [5:0] field_width = '0;
  logic pad_after = 1'b0;
  logic plus_sign = 1'b0;
  logic blank_sign = 1'b0;
  logic zero_pad = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_char;
  logic last;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } char_t;

  char_t pending_chars[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  integer_field_formatter DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .value(value),
    .is_signed(is_signed), .radix(radix), .upper_case(upper_case),
    .field_width(field_width), .pad_after(pad_after), .plus_sign(plus_sign),
    .blank_sign(blank_sign), .zero_pad(zero_pad), .empty(empty), .pop(pop),
    .out_char(out_char), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicts the characters of one request and queues them.
  task automatic format_field(input logic [31:0] v, input logic sgn, input logic [5:0] rdx,
                              input logic up, input logic [5:0] wid, input logic la,
                              input logic ps, input logic ss, input logic zp);
    logic [7:0] digs[$];
    logic [7:0] line[$];
    logic [7:0] sign_ch;
    logic has_sign;
    logic [31:0] mag;
    int r, d, pad, n;
    char_t c;
    r = rdx < 2 ? 2 : (rdx > 36 ? 36 : rdx);
    mag = v;
    has_sign = 1'b0;
    sign_ch = CHAR_SPACE;
    if (sgn) begin
      if (v[31]) begin
        mag = -v;
        has_sign = 1'b1;
        sign_ch = CHAR_MINUS;
      end else if (ps) begin
        has_sign = 1'b1;
        sign_ch = CHAR_PLUS;
      end else if (ss) begin
        has_sign = 1'b1;
      end
    end
    do begin
      d = mag % r;
      digs.push_front(d < 10 ? 8'd48 + d[7:0] : (up ? 8'd55 : 8'd87) + d[7:0]);
      mag = mag / r;
    end while (mag != 0);
    pad = wid - digs.size() - has_sign;
    if (pad < 0) pad = 0;
    if (!la && !zp) repeat (pad) line.push_back(CHAR_SPACE);
    if (has_sign) line.push_back(sign_ch);
    if (!la && zp) repeat (pad) line.push_back(CHAR_ZERO);
    foreach (digs[i]) line.push_back(digs[i]);
    if (la) repeat (pad) line.push_back(CHAR_SPACE);
    n = line.size() > OUT_LIMIT ? OUT_LIMIT : line.size();
    for (int i = 0; i < n; i++) begin
      c.ch = line[i];
      c.fin = (i == n - 1);
      pending_chars.push_back(c);
    end
  endtask

  task automatic send_request(input logic [31:0] v, input logic sgn, input logic [5:0] rdx,
                              input logic up, input logic [5:0] wid, input logic la,
                              input logic ps, input logic ss, input logic zp);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    value <= v; is_signed <= sgn; radix <= rdx; upper_case <= up;
    field_width <= wid; pad_after <= la; plus_sign <= ps; blank_sign <= ss;
    zero_pad <= zp;
    @(posedge clk);
    while (full) @(posedge clk);
    format_field(v, sgn, rdx, up, wid, la, ps, ss, zp);
  endtask

  task automatic send_random(input int k);
    logic [31:0] v;
    logic [5:0] rdx;
    logic [5:0] wid;
    logic [6:0] flags;
    repeat (k) begin
      case ($urandom_range(3))
        0: v = $urandom_range(20);
        1: v = -$urandom_range(20);
        2: v = {$urandom_range(1) ? 1'b1 : 1'b0, 31'd0} | $urandom_range(3);
        default: v = $urandom;
      endcase
      rdx = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(2, 36));
      wid = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
      flags = 7'($urandom_range(127));
      send_request(v, flags[0], rdx, flags[1], wid, flags[2], flags[3], flags[4],
                   flags[5]);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(32'd0, 1'b0, 6'd10, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(32'hffffffff, 1'b0, 6'd2, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(32'h80000000, 1'b1, 6'd10, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(32'h80000000, 1'b1, 6'd2, 1'b0, 6'd63, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(32'h7fffffff, 1'b1, 6'd36, 1'b1, 6'd20, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(32'h7fffffff, 1'b1, 6'd36, 1'b0, 6'd20, 1'b1, 1'b0, 1'b1, 1'b1);
    send_request(32'hdeadbeef, 1'b0, 6'd16, 1'b1, 6'd12, 1'b0, 1'b1, 1'b1, 1'b1);
    send_request(32'hdeadbeef, 1'b0, 6'd16, 1'b0, 6'd12, 1'b1, 1'b0, 1'b0, 1'b0);
    send_request(32'd5, 1'b1, 6'd0, 1'b0, 6'd4, 1'b0, 1'b0, 1'b1, 1'b0);
    send_request(32'd5, 1'b1, 6'd1, 1'b0, 6'd4, 1'b0, 1'b0, 1'b1, 1'b1);
    send_request(32'd35, 1'b1, 6'd63, 1'b1, 6'd4, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(32'd35, 1'b1, 6'd37, 1'b0, 6'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(-32'd42, 1'b1, 6'd10, 1'b0, 6'd8, 1'b0, 1'b1, 1'b1, 1'b1);
    send_request(-32'd42, 1'b1, 6'd10, 1'b0, 6'd8, 1'b0, 1'b0, 1'b0, 1'b0);
    send_request(-32'd42, 1'b0, 6'd8, 1'b0, 6'd8, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(32'd0, 1'b1, 6'd3, 1'b0, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1);
    send_request(32'h55555555, 1'b0, 6'd2, 1'b0, 6'd40, 1'b0, 1'b0, 1'b0, 1'b1);
    send_request(32'haaaaaaaa, 1'b1, 6'd7, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(100);
    send_idle_pct = 87; recv_stall_pct = 0;  send_random(100);
    send_idle_pct = 0;  recv_stall_pct = 87; send_random(100);
    send_idle_pct = 31; recv_stall_pct = 31; send_random(90);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(20);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (!empty && pop) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected result out_char=%h", out_char);
          errors++;
        end else begin
          if (out_char !== pending_chars[0].ch) begin
            $error("out_char expected %h actual %h", pending_chars[0].ch, out_char);
            errors++;
          end
          if (last !== pending_chars[0].fin) begin
            $error("last expected %b actual %b", pending_chars[0].fin, last);
            errors++;
          end
          void'(pending_chars.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    wait_drained();
    repeat (500) @(posedge clk);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
